>>> hdl/triangle_region_classifier_defines.svh
// Assertion macros shared by the classifier RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef TRIANGLE_REGION_CLASSIFIER_DEFINES_SVH
`define TRIANGLE_REGION_CLASSIFIER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define TRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: label failed");
// consequence in the next cycle
`define TRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: label failed");
`endif

>>> hdl/trc_pkg.sv
// Package for the triangle region classifier: sizes, field widths and opcodes.
// Depends on nothing.
package trc_pkg;
    localparam int REGION_SLOTS_DEF      = 16;
    localparam int PLANES_PER_REGION_DEF = 8;
    localparam int COORD_BITS_DEF        = 32;
    localparam int CFG_BITS              = 5;
    localparam int SLOT_FIELD_BITS       = 4;
    localparam int PIDX_FIELD_BITS       = 4;
    localparam int FIELD_BITS            = 32;

    typedef enum logic [1:0] {
        OP_LOAD_PLANE = 2'd0,
        OP_SET_COUNT  = 2'd1,
        OP_CLASSIFY   = 2'd2,
        OP_NONE       = 2'd3
    } opcode_t;
endpackage

>>> hdl/trc_vertex_cell.sv
// One cell of the vertex chain: tests one vertex against the plane on the bus.
// Stage 1 registers three products, stage 2 the sum against the scaled offset.
// Depends on trc_pkg.
module trc_vertex_cell
    import trc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic signed [COORD_BITS-1:0] nx,
    input  logic signed [COORD_BITS-1:0] ny,
    input  logic signed [COORD_BITS-1:0] nz,
    input  logic signed [COORD_BITS-1:0] d,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  logic signed [COORD_BITS-1:0] pz,
    output logic                         outside
);
    localparam int PW = 2 * COORD_BITS;
    localparam int SW = PW + 3;

    logic signed [PW-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [SW-1:0] offset_reg;
    logic                 outside_reg;
    logic signed [SW-1:0] sum;

    always_ff @(posedge clk)
    begin
        prod_x_reg <= nx * px;
        prod_y_reg <= ny * py;
        prod_z_reg <= nz * pz;
        offset_reg <= SW'(d) <<< 16;
        outside_reg <= (sum > offset_reg);
    end

    assign sum = SW'(prod_x_reg) + SW'(prod_y_reg) + SW'(prod_z_reg);
    assign outside = outside_reg;
endmodule

>>> hdl/trc_plane_store.sv
// Plane memory and per-slot plane counts.
// Depends on trc_pkg.
module trc_plane_store
    import trc_pkg::*;
#(
    parameter int REGION_SLOTS      = REGION_SLOTS_DEF,
    parameter int PLANES_PER_REGION = PLANES_PER_REGION_DEF,
    parameter int COORD_BITS        = COORD_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_plane,
    input  logic [$clog2(REGION_SLOTS*PLANES_PER_REGION)-1:0] wr_addr,
    input  logic [4*COORD_BITS-1:0]              wr_data,
    input  logic                                 wr_count,
    input  logic [$clog2(REGION_SLOTS)-1:0]      wr_slot,
    input  logic [$clog2(PLANES_PER_REGION+1)-1:0] wr_count_val,
    input  logic [$clog2(REGION_SLOTS*PLANES_PER_REGION)-1:0] rd_addr,
    output logic [4*COORD_BITS-1:0]              rd_data,
    input  logic [$clog2(REGION_SLOTS)-1:0]      cnt_slot,
    output logic [$clog2(PLANES_PER_REGION+1)-1:0] cnt_val
);
    localparam int DEPTH = REGION_SLOTS * PLANES_PER_REGION;
    localparam int CW    = $clog2(PLANES_PER_REGION + 1);

    logic [4*COORD_BITS-1:0] mem [DEPTH];
    logic [CW-1:0]           count_reg [REGION_SLOTS];
    logic [4*COORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_plane)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REGION_SLOTS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (wr_count)
        begin
            count_reg[wr_slot] <= wr_count_val;
        end
    end

    assign rd_data = rd_data_reg;
    assign cnt_val = count_reg[cnt_slot];
endmodule

>>> hdl/triangle_region_classifier.sv
// Top level of the triangle region classifier: sequencer, plane store, vertex cells.
// Depends on trc_pkg, trc_plane_store, trc_vertex_cell and the defines header.
//
// Usage: items enter on s_axis (tdata packed fields, see port comment). Load-plane
// and set-count items produce no output. A classify item walks the selected regions
// in order until one matches, one plane per cycle; three vertex cells test A, B and C
// against that plane in parallel through a three-stage pipe (memory read, products,
// compare). A searched region costs its plane count in issues, then one empty issue
// slot, a drain of the pipe and the decision; after the last region is decided the
// result is loaded into the output register from the output state. Search time is
// set by the single plane memory read port and the pipe drain at each region end.
// The input is ready again as the result appears. The result (found_slot, is_default)
// sits in an output register on m_axis until taken; the block accepts the next item
// meanwhile, but holds a new classify result until the register is free.
// cfg_tvalid/cfg_tready write regions_in_use; values above REGION_SLOTS saturate.
// Reset clears counts, the register and the output; plane contents are undefined
// until loaded.
`include "triangle_region_classifier_defines.svh"
module triangle_region_classifier
    import trc_pkg::*;
#(
    parameter int REGION_SLOTS      = REGION_SLOTS_DEF,
    parameter int PLANES_PER_REGION = PLANES_PER_REGION_DEF,
    parameter int COORD_BITS        = COORD_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_tvalid,
    output logic         cfg_tready,
    input  logic [7:0]   cfg_tdata,     // regions_in_use [4:0]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[1:0] region_slot[5:2] plane_index[9:6] ax ay az bx by bz cx cy cz (32 each from 10)
    input  logic [303:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata   // found_slot[4:0] is_default[5]
);
    localparam int SB = $clog2(REGION_SLOTS);
    localparam int PB = $clog2(PLANES_PER_REGION);
    localparam int CW = $clog2(PLANES_PER_REGION + 1);
    localparam int AB = $clog2(REGION_SLOTS * PLANES_PER_REGION);
    localparam int RB = $clog2(REGION_SLOTS + 1);
    localparam int CB = COORD_BITS;

    typedef enum logic [1:0] { ST_IDLE, ST_WALK, ST_DRAIN, ST_OUT } state_t;

    state_t              state_reg;
    logic [RB-1:0]       regions_reg;
    logic [RB-1:0]       limit_reg;
    logic [SB:0]         slot_reg;
    logic [CW-1:0]       plane_reg;
    logic [2:0]          drain_reg;
    logic [2:0]          vld_reg;
    logic                fail_reg;
    logic [CB-1:0]       vtx_reg [9];
    logic                out_valid_reg;
    logic [4:0]          out_slot_reg;
    logic                out_def_reg;

    opcode_t             op;
    logic [SLOT_FIELD_BITS-1:0] in_slot;
    logic [PIDX_FIELD_BITS-1:0] in_pidx;
    logic [FIELD_BITS-1:0] f [9];
    logic                in_acc;
    logic                wr_plane, wr_count;
    logic [CW-1:0]       cnt_val, cnt_sat;
    logic [4*CB-1:0]     rd_data;
    logic [2:0]          outs;
    logic                issue;
    logic                out_load;
    logic [RB-1:0]       cfg_sat;

    assign op      = opcode_t'(s_axis_tdata[1:0]);
    assign in_slot = s_axis_tdata[5:2];
    assign in_pidx = s_axis_tdata[9:6];
    for (genvar g = 0; g < 9; g++)
    begin : g_field
        assign f[g] = s_axis_tdata[10 + 32*g +: 32];
    end

    assign cfg_tready    = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign wr_plane = in_acc && op == OP_LOAD_PLANE && 32'(in_slot) < REGION_SLOTS
                      && 32'(in_pidx) < PLANES_PER_REGION;
    assign wr_count = in_acc && op == OP_SET_COUNT && 32'(in_slot) < REGION_SLOTS;
    assign cnt_sat  = (32'(in_pidx) > PLANES_PER_REGION) ? CW'(PLANES_PER_REGION)
                                                         : CW'(in_pidx);
    assign cfg_sat  = (32'(cfg_tdata[4:0]) > REGION_SLOTS) ? RB'(REGION_SLOTS)
                                                           : RB'(cfg_tdata[4:0]);

    trc_plane_store #(
        .REGION_SLOTS(REGION_SLOTS), .PLANES_PER_REGION(PLANES_PER_REGION),
        .COORD_BITS(COORD_BITS)
    ) u_store (
        .clk(clk), .rst_n(rst_n),
        .wr_plane(wr_plane),
        .wr_addr(AB'(32'(in_slot) * PLANES_PER_REGION + 32'(in_pidx))),
        .wr_data({CB'(f[3]), CB'(f[2]), CB'(f[1]), CB'(f[0])}),
        .wr_count(wr_count), .wr_slot(SB'(in_slot)), .wr_count_val(cnt_sat),
        .rd_addr(AB'(32'(slot_reg[SB-1:0]) * PLANES_PER_REGION + 32'(plane_reg))),
        .rd_data(rd_data),
        .cnt_slot(slot_reg[SB-1:0]), .cnt_val(cnt_val)
    );

    for (genvar v = 0; v < 3; v++)
    begin : g_cell
        trc_vertex_cell #(.COORD_BITS(COORD_BITS)) u_cell (
            .clk(clk),
            .nx(rd_data[0*CB +: CB]), .ny(rd_data[1*CB +: CB]),
            .nz(rd_data[2*CB +: CB]), .d(rd_data[3*CB +: CB]),
            .px(vtx_reg[3*v]), .py(vtx_reg[3*v+1]), .pz(vtx_reg[3*v+2]),
            .outside(outs[v])
        );
    end

    assign issue    = (state_reg == ST_WALK) && (plane_reg < cnt_val);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int i = 0; i < 9; i++)
            begin
                vtx_reg[i] <= CB'(f[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            regions_reg   <= '0;
            limit_reg     <= '0;
            slot_reg      <= '0;
            plane_reg     <= '0;
            drain_reg     <= '0;
            vld_reg       <= '0;
            fail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_slot_reg  <= '0;
            out_def_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_tvalid)
            begin
                regions_reg <= cfg_sat;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_slot_reg  <= (limit_reg == '0) ? 5'(REGION_SLOTS)
                                                   : 5'(slot_reg);
                out_def_reg   <= (limit_reg == '0)
                                 || (32'(slot_reg) == REGION_SLOTS);
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            vld_reg <= {vld_reg[1:0], issue};
            if (vld_reg[2] && (|outs))
            begin
                fail_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && op == OP_CLASSIFY)
                    begin
                        limit_reg <= regions_reg;
                        slot_reg  <= '0;
                        plane_reg <= '0;
                        fail_reg  <= 1'b0;
                        state_reg <= (regions_reg == '0) ? ST_OUT : ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    if (issue)
                    begin
                        plane_reg <= plane_reg + 1'b1;
                    end
                    else
                    begin
                        drain_reg <= 3'd4;
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (drain_reg != '0)
                    begin
                        drain_reg <= drain_reg - 1'b1;
                    end
                    else if (!fail_reg)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else if (32'(slot_reg) + 1 >= 32'(limit_reg))
                    begin
                        slot_reg  <= (SB+1)'(REGION_SLOTS);
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        slot_reg  <= slot_reg + 1'b1;
                        plane_reg <= '0;
                        fail_reg  <= 1'b0;
                        state_reg <= ST_WALK;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_def_reg, out_slot_reg};

    `TRC_ASSERT_IMP(a_ready_idle, clk, rst_n, s_axis_tready, state_reg == ST_IDLE)
    `TRC_ASSERT_IMP(a_def_slot, clk, rst_n, m_axis_tvalid && m_axis_tdata[5],
                    32'(m_axis_tdata[4:0]) == REGION_SLOTS)
    `TRC_ASSERT_IMP(a_issue_walk, clk, rst_n, issue, 32'(slot_reg) < REGION_SLOTS)
    `TRC_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid)
endmodule

>>> verif/testbench.sv
// Self-checking bench for triangle_region_classifier: loads half-space regions,
// classifies triangles and compares every result with an in-bench region search.
// Depends on trc_pkg and the classifier RTL.
module testbench;
    import trc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = REGION_SLOTS_DEF;
    localparam int NPLANE = PLANES_PER_REGION_DEF;
    localparam int RANDOM_ITEMS = 1250;

    typedef struct packed {
        logic [4:0] found_slot;
        logic       is_default;
    } verdict_t;

    typedef struct {
        opcode_t            op;
        logic [3:0]         slot;
        logic [3:0]         pidx;
        logic signed [31:0] v [9];
    } item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_tvalid = 1'b0;
    logic cfg_tready;
    logic [7:0] cfg_tdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [303:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    logic signed [31:0] nx_tab [NSLOT*NPLANE];
    logic signed [31:0] ny_tab [NSLOT*NPLANE];
    logic signed [31:0] nz_tab [NSLOT*NPLANE];
    logic signed [31:0] off_tab [NSLOT*NPLANE];
    bit loaded [NSLOT*NPLANE];
    int unsigned count_tab [NSLOT];
    int unsigned regions_searched;
    int unsigned limit_vals [5] = '{16, 7, 1, 20, 12};

    verdict_t pending_verdicts [$];
    int errors = 0;
    bit rx_quiet = 1'b1;
    bit rx_hold = 1'b0;
    bit tx_quiet = 1'b1;

    triangle_region_classifier DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_tvalid(cfg_tvalid),
        .cfg_tready(cfg_tready),
        .cfg_tdata(cfg_tdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report(input string what);
        $display("[%0t] %s", $realtime, what);
        errors++;
    endtask

    // exact n.p > d<<16 test
    function automatic bit beyond_plane(int k, logic signed [31:0] px, logic signed [31:0] py,
                                        logic signed [31:0] pz);
        logic signed [127:0] acc;
        logic signed [127:0] lim;
        acc = 128'(nx_tab[k]) * 128'(px) + 128'(ny_tab[k]) * 128'(py)
            + 128'(nz_tab[k]) * 128'(pz);
        lim = 128'(off_tab[k]) <<< 16;
        return acc > lim;
    endfunction

    function automatic verdict_t locate_region(item_t it);
        verdict_t r;
        bit hit;
        int k;
        r.found_slot = 5'(NSLOT);
        r.is_default = 1'b1;
        for (int s = 0; s < regions_searched; s++)
        begin
            hit = 1'b1;
            for (int j = 0; j < count_tab[s] && hit; j++)
            begin
                k = s * NPLANE + j;
                for (int p = 0; p < 3; p++)
                    if (beyond_plane(k, it.v[3*p], it.v[3*p+1], it.v[3*p+2]))
                        hit = 1'b0;
            end
            if (hit)
            begin
                r.found_slot = 5'(s);
                r.is_default = 1'b0;
                return r;
            end
        end
        return r;
    endfunction

    function automatic void apply_item(item_t it);
        int k;
        case (it.op)
            OP_LOAD_PLANE:
                if (it.pidx < NPLANE)
                begin
                    k = it.slot * NPLANE + it.pidx;
                    nx_tab[k] = it.v[0];
                    ny_tab[k] = it.v[1];
                    nz_tab[k] = it.v[2];
                    off_tab[k] = it.v[3];
                    loaded[k] = 1'b1;
                end
            OP_SET_COUNT:
                count_tab[it.slot] = (it.pidx > NPLANE) ? NPLANE : it.pidx;
            OP_CLASSIFY:
                pending_verdicts.insert(pending_verdicts.size(), locate_region(it));
            default: ;
        endcase
    endfunction

    task automatic send_item(item_t it);
        logic [303:0] packed_word;
        packed_word = '0;
        packed_word[1:0] = it.op;
        packed_word[5:2] = it.slot;
        packed_word[9:6] = it.pidx;
        for (int i = 0; i < 9; i++)
            packed_word[10 + 32*i +: 32] = it.v[i];
        while (!tx_quiet && $urandom_range(99) < 11)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= packed_word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        apply_item(it);
    endtask

    // classify with an expected verdict read straight off the contract
    task automatic send_typed(item_t it, verdict_t want);
        send_item(it);
        if (pending_verdicts[$] !== want)
            report($sformatf("predictor gives %h, typed %h", pending_verdicts[$], want));
        pending_verdicts[$] = want;
    endtask

    task automatic write_regions(int unsigned value);
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_tvalid <= 1'b1;
        cfg_tdata <= 8'(value);
        @(posedge clk);
        while (!cfg_tready)
            @(posedge clk);
        cfg_tvalid <= 1'b0;
        regions_searched = ((value & 31) > NSLOT) ? NSLOT : (value & 31);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'($urandom);
            default: return 32'($signed($urandom_range(2 * 65536 * 40)) - 65536 * 40);
        endcase
    endfunction

    function automatic item_t mk(opcode_t op, int s, int p, logic signed [31:0] a,
                                 logic signed [31:0] b, logic signed [31:0] c,
                                 logic signed [31:0] d);
        item_t it;
        it.op = op;
        it.slot = 4'(s);
        it.pidx = 4'(p);
        foreach (it.v[i])
            it.v[i] = rand_coord();
        it.v[0] = a;
        it.v[1] = b;
        it.v[2] = c;
        it.v[3] = d;
        return it;
    endfunction

    // axis-aligned box half-spaces, so well-formed triangles land inside often
    task automatic load_box(int s, int half);
        for (int j = 0; j < 6; j++)
        begin
            logic signed [31:0] n [3];
            n = '{0, 0, 0};
            n[j / 2] = (j % 2) ? -32'sd65536 : 32'sd65536;
            send_item(mk(OP_LOAD_PLANE, s, j, n[0], n[1], n[2], 32'(half * 65536)));
        end
    endtask

    task automatic random_item();
        item_t it;
        int sel;
        int s;
        sel = $urandom_range(99);
        s = $urandom_range(NSLOT - 1);
        if (sel < 8)
        begin
            it = mk(OP_LOAD_PLANE, s, $urandom_range(15), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord());
            if (it.pidx < NPLANE && !loaded[s * NPLANE + it.pidx] && count_tab[s] > it.pidx)
                it.pidx = 4'd15;
        end
        else if (sel < 12)
        begin
            int c;
            c = 0;
            while (c < NPLANE && loaded[s * NPLANE + c])
                c++;
            it = mk(OP_SET_COUNT, s, $urandom_range(c), 0, 0, 0, 0);
            if (c == NPLANE && $urandom_range(1))
                it.pidx = 4'($urandom_range(15, 9));
        end
        else if (sel < 14)
            it = mk(OP_NONE, s, $urandom_range(15), rand_coord(), 0, 0, 0);
        else
        begin
            it = mk(OP_CLASSIFY, s, $urandom_range(15), 0, 0, 0, 0);
            foreach (it.v[i])
                it.v[i] = ($urandom_range(9) == 0) ? rand_coord()
                          : 32'($signed($urandom_range(2 * 65536 * 12)) - 65536 * 12);
        end
        send_item(it);
    endtask

    always @(posedge clk)
    begin
        verdict_t got;
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.found_slot = m_axis_tdata[4:0];
            got.is_default = m_axis_tdata[5];
            if (pending_verdicts.size() == 0)
                report($sformatf("unexpected transaction %h", m_axis_tdata));
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.found_slot !== want.found_slot)
                    report($sformatf("found_slot %0d, wanted %0d", got.found_slot,
                                     want.found_slot));
                if (got.is_default !== want.is_default)
                    report($sformatf("is_default %0b, wanted %0b", got.is_default,
                                     want.is_default));
            end
        end
    end

    always @(posedge clk)
        m_axis_tready <= !rx_hold && (rx_quiet || $urandom_range(99) >= 11);

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        item_t directed [$];
        foreach (count_tab[i])
            count_tab[i] = 0;
        foreach (loaded[i])
            loaded[i] = 1'b0;
        regions_searched = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: nothing searched, default answer
        send_typed(mk(OP_CLASSIFY, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0),
                   verdict_t'{5'(NSLOT), 1'b1});
        send_item(mk(OP_NONE, 15, 15, 32'sh7fff_ffff, 0, 0, 0));
        write_regions(31);
        // all counts zero: slot 0 matches everything
        send_typed(mk(OP_CLASSIFY, 9, 9, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                      32'sh8000_0000), verdict_t'{5'd0, 1'b0});
        directed = {
            mk(OP_LOAD_PLANE, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 0, 32'sh8000_0000),
            mk(OP_LOAD_PLANE, 0, 9, 0, 0, 0, 0),
            mk(OP_LOAD_PLANE, 0, 15, 0, 0, 0, 0),
            mk(OP_SET_COUNT, 0, 1, 0, 0, 0, 0),
            mk(OP_LOAD_PLANE, 1, 0, 0, 0, 0, 32'sh7fff_ffff),
            mk(OP_SET_COUNT, 1, 1, 0, 0, 0, 0),
            mk(OP_CLASSIFY, 0, 0, 0, 0, 0, 0),
            mk(OP_CLASSIFY, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
               32'sh8000_0000),
            mk(OP_CLASSIFY, 0, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
               32'sh7fff_ffff)
        };
        foreach (directed[i])
            send_item(directed[i]);
        load_box(15, 10);
        send_item(mk(OP_SET_COUNT, 15, 6, 0, 0, 0, 0));
        for (int i = 0; i < 8; i++)
            send_item(mk(OP_LOAD_PLANE, 14, i, 32'sh8000_0000, 32'sh7fff_ffff,
                         32'sh8000_0000, 32'sh7fff_ffff));
        send_item(mk(OP_SET_COUNT, 14, 15, 0, 0, 0, 0));
        send_item(mk(OP_CLASSIFY, 0, 0, 0, 0, 0, 0));
        write_regions(0);
        send_typed(mk(OP_CLASSIFY, 0, 0, 0, 0, 0, 0), verdict_t'{5'(NSLOT), 1'b1});
        write_regions(16);

        // long receiver hold-off while the sender keeps going
        rx_hold = 1'b1;
        tx_quiet = 1'b1;
        fork
            begin
                repeat (3000) @(posedge clk);
                rx_hold = 1'b0;
            end
            for (int i = 0; i < 40; i++)
                send_item(mk(OP_CLASSIFY, 0, 0, 0, 0, 0, 0));
        join

        for (int s = 0; s < NSLOT; s++)
        begin
            load_box(s, 2 + s % 12);
            send_item(mk(OP_SET_COUNT, s, 6, 0, 0, 0, 0));
        end
        foreach (limit_vals[p])
        begin
            write_regions(limit_vals[p]);
            rx_quiet = (p == 1);
            tx_quiet = (p == 1);
            for (int i = 0; i < RANDOM_ITEMS / 5; i++)
                random_item();
        end

        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
